// ===== hdl/lcabl_pkg.sv =====
package lcabl_pkg;

    localparam int NODE_BITS_DEF = 16;
    localparam int LEVELS_DEF    = 16;
    localparam int ID_W          = 16;
    localparam int DEPTH_W       = 16;
    localparam int IN_DATA_W     = 32;
    localparam int OUT_DATA_W    = 24;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_UNKNOWN = 2'd1,
        STAT_PRESENT = 2'd2
    } stat_t;

    typedef enum logic [1:0] {
        REL_NONE  = 2'd0,
        REL_A_ANC = 2'd1,
        REL_B_ANC = 2'd2
    } rel_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_EVAL,
        ST_INS_RD,
        ST_INS_WR,
        ST_LIFT_ANC,
        ST_LIFT_DEP,
        ST_LIFT_UPD,
        ST_SAME,
        ST_CLIMB_RD,
        ST_CLIMB_UPD,
        ST_ROOT_RD,
        ST_ROOT_UPD,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_EVAL,
        OP_INS_RD,
        OP_INS_WR,
        OP_LIFT_DEP,
        OP_LIFT_UPD,
        OP_SAME,
        OP_CLIMB_UPD,
        OP_ROOT_RD,
        OP_ROOT_UPD,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   lvl_init;
        logic   lvl_step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_query;
        logic err;
        logic lvl_last;
        logic same;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== hdl/lca_binary_lifting_top.sv =====
// A request goes from accept through the presence check and evaluation to the result;
// an insert fills its ancestor entries level by level, a query lifts the deeper node,
// then climbs both unless one is the other's ancestor; a rejected request ends at once.
// The rate is set by dependent reads of the ancestor and depth tables, one level a step.
// Reset is synchronous, active low; afterwards the presence table is swept clear
// with s_tready low.
module lca_binary_lifting_top #(
    parameter int NODE_BITS = lcabl_pkg::NODE_BITS_DEF,
    parameter int LEVELS    = lcabl_pkg::LEVELS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lcabl_pkg::IN_DATA_W-1:0]     s_tdata,  // node_a[15:0], node_b[31:16]
    input  logic                                s_tuser,  // cmd[0]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lcabl_pkg::OUT_DATA_W-1:0]    m_tdata   // relation[1:0], ancestor[17:2],
                                                          // status[19:18], zero[23:20]
);

    lcabl_pkg::ctrl_cmd_t cmd;
    lcabl_pkg::dp_stat_t  stat;

    lcabl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    lcabl_dpath #(
        .NODE_BITS (NODE_BITS),
        .LEVELS    (LEVELS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_cmd    (s_tuser),
        .in_node_a (s_tdata[15:0]),
        .in_node_b (s_tdata[31:16]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== hdl/lcabl_ctrl.sv =====
module lcabl_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output lcabl_pkg::ctrl_cmd_t  cmd,
    input  lcabl_pkg::dp_stat_t   stat
);

    lcabl_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lcabl_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd.op       = lcabl_pkg::OP_NONE;
        cmd.lvl_init = 1'b0;
        cmd.lvl_step = 1'b0;
        s_tready     = 1'b0;
        unique case (state_reg)
            lcabl_pkg::ST_CLEAR: begin
                cmd.op = lcabl_pkg::OP_CLEAR;
                if (stat.clr_last) state_next = lcabl_pkg::ST_IDLE;
            end
            lcabl_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = lcabl_pkg::OP_LOAD;
                    state_next = lcabl_pkg::ST_CHECK;
                end
            end
            lcabl_pkg::ST_CHECK: begin
                state_next = lcabl_pkg::ST_EVAL;
            end
            lcabl_pkg::ST_EVAL: begin
                cmd.op       = lcabl_pkg::OP_EVAL;
                cmd.lvl_init = 1'b1;
                if (stat.err)           state_next = lcabl_pkg::ST_DONE;
                else if (stat.is_query) state_next = lcabl_pkg::ST_LIFT_ANC;
                else                    state_next = lcabl_pkg::ST_INS_RD;
            end
            lcabl_pkg::ST_INS_RD: begin
                cmd.op     = lcabl_pkg::OP_INS_RD;
                state_next = lcabl_pkg::ST_INS_WR;
            end
            lcabl_pkg::ST_INS_WR: begin
                cmd.op = lcabl_pkg::OP_INS_WR;
                if (stat.lvl_last) begin
                    state_next = lcabl_pkg::ST_DONE;
                end else begin
                    cmd.lvl_step = 1'b1;
                    state_next   = lcabl_pkg::ST_INS_RD;
                end
            end
            lcabl_pkg::ST_LIFT_ANC: begin
                state_next = lcabl_pkg::ST_LIFT_DEP;
            end
            lcabl_pkg::ST_LIFT_DEP: begin
                cmd.op     = lcabl_pkg::OP_LIFT_DEP;
                state_next = lcabl_pkg::ST_LIFT_UPD;
            end
            lcabl_pkg::ST_LIFT_UPD: begin
                cmd.op = lcabl_pkg::OP_LIFT_UPD;
                if (stat.lvl_last) begin
                    state_next = lcabl_pkg::ST_SAME;
                end else begin
                    cmd.lvl_step = 1'b1;
                    state_next   = lcabl_pkg::ST_LIFT_ANC;
                end
            end
            lcabl_pkg::ST_SAME: begin
                cmd.op = lcabl_pkg::OP_SAME;
                if (stat.same) begin
                    state_next = lcabl_pkg::ST_DONE;
                end else begin
                    cmd.lvl_init = 1'b1;
                    state_next   = lcabl_pkg::ST_CLIMB_RD;
                end
            end
            lcabl_pkg::ST_CLIMB_RD: begin
                state_next = lcabl_pkg::ST_CLIMB_UPD;
            end
            lcabl_pkg::ST_CLIMB_UPD: begin
                cmd.op = lcabl_pkg::OP_CLIMB_UPD;
                if (stat.lvl_last) begin
                    state_next = lcabl_pkg::ST_ROOT_RD;
                end else begin
                    cmd.lvl_step = 1'b1;
                    state_next   = lcabl_pkg::ST_CLIMB_RD;
                end
            end
            lcabl_pkg::ST_ROOT_RD: begin
                cmd.op     = lcabl_pkg::OP_ROOT_RD;
                state_next = lcabl_pkg::ST_ROOT_UPD;
            end
            lcabl_pkg::ST_ROOT_UPD: begin
                cmd.op     = lcabl_pkg::OP_ROOT_UPD;
                state_next = lcabl_pkg::ST_DONE;
            end
            lcabl_pkg::ST_DONE: begin
                // hold the result until the output register frees up
                if (stat.out_free) begin
                    cmd.op     = lcabl_pkg::OP_FINISH;
                    state_next = lcabl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lcabl_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

// ===== hdl/lcabl_dpath.sv =====
module lcabl_dpath #(
    parameter int NODE_BITS = lcabl_pkg::NODE_BITS_DEF,
    parameter int LEVELS    = lcabl_pkg::LEVELS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  lcabl_pkg::ctrl_cmd_t                cmd,
    output lcabl_pkg::dp_stat_t                 stat,
    input  logic                                in_cmd,
    input  logic [lcabl_pkg::ID_W-1:0]          in_node_a,
    input  logic [lcabl_pkg::ID_W-1:0]          in_node_b,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lcabl_pkg::OUT_DATA_W-1:0]    m_tdata
);

    localparam int ID_W     = lcabl_pkg::ID_W;
    localparam int DEPTH_W  = lcabl_pkg::DEPTH_W;
    localparam int LW       = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int NODE_CNT = 1 << NODE_BITS;
    localparam int AW       = NODE_BITS + LW;
    localparam int ANC_CNT  = 1 << AW;

    // tables
    logic               pres_mem [NODE_CNT];
    logic [DEPTH_W-1:0] dep_mem  [NODE_CNT];
    logic [ID_W-1:0]    anc_mem  [ANC_CNT];

    // request payload and working registers
    logic               cmd_reg;
    logic [ID_W-1:0]    a_reg, b_reg, x_reg, y_reg, p_reg, res_reg;
    logic [DEPTH_W-1:0] dy_reg;
    lcabl_pkg::stat_t   stat_reg;
    logic [LW-1:0]      lvl_reg;
    logic [NODE_BITS-1:0] clr_reg;

    // registered read data
    logic               pres_rd0_reg, pres_rd1_reg;
    logic [DEPTH_W-1:0] dep_rd0_reg, dep_rd1_reg;
    logic [ID_W-1:0]    anc_rd0_reg, anc_rd1_reg;
    logic               dep_z0_reg, dep_z1_reg, anc_z0_reg, anc_z1_reg;

    // output register
    logic               out_valid_reg;
    lcabl_pkg::rel_t    out_rel_reg;
    logic [ID_W-1:0]    out_anc_reg;
    lcabl_pkg::stat_t   out_stat_reg;

    logic [NODE_BITS-1:0] a_idx, b_idx, x_idx, y_idx, p_idx;
    logic [NODE_BITS-1:0] pres_wa, dep_wa, dep_ra0;
    logic [AW-1:0]        anc_wa, anc_ra0, anc_ra1;
    logic                 pres_we, pres_wd, dep_we, anc_we;
    logic [DEPTH_W-1:0]   dep_wd;
    logic [ID_W-1:0]      anc_wd;
    logic [ID_W-1:0]      anc_v0, anc_v1, p_val;
    logic [DEPTH_W-1:0]   dep_v0, dep_v1, dep_inc;
    logic                 a_inr, b_inr, a_known, b_known, ins_ok;
    logic                 lvl_last;
    lcabl_pkg::stat_t     stat_eval;
    logic [LW-1:0]        lvl_start;

    assign a_idx = NODE_BITS'(a_reg);
    assign b_idx = NODE_BITS'(b_reg);
    assign x_idx = NODE_BITS'(x_reg);
    assign y_idx = NODE_BITS'(y_reg);

    // node 0 sits above every root: depth 0 and all ancestors 0
    assign anc_v0 = anc_z0_reg ? '0 : anc_rd0_reg;
    assign anc_v1 = anc_z1_reg ? '0 : anc_rd1_reg;
    assign dep_v0 = dep_z0_reg ? '0 : dep_rd0_reg;
    assign dep_v1 = dep_z1_reg ? '0 : dep_rd1_reg;
    assign p_val  = anc_v0;
    assign p_idx  = NODE_BITS'(p_val);
    assign dep_inc = (dep_v1 == '1) ? dep_v1 : dep_v1 + DEPTH_W'(1);

    assign a_inr   = ((32'(a_reg) >> NODE_BITS) == 32'd0);
    assign b_inr   = ((32'(b_reg) >> NODE_BITS) == 32'd0);
    assign a_known = (a_reg != '0) && a_inr && pres_rd0_reg;
    assign b_known = (b_reg != '0) && b_inr && pres_rd1_reg;

    always_comb begin
        if (cmd_reg == lcabl_pkg::CMD_QUERY) begin
            stat_eval = (a_known && b_known) ? lcabl_pkg::STAT_OK : lcabl_pkg::STAT_UNKNOWN;
        end else if (!((a_reg != '0) && a_inr) || !((b_reg == '0) || b_known)) begin
            stat_eval = lcabl_pkg::STAT_UNKNOWN;
        end else if (pres_rd0_reg) begin
            stat_eval = lcabl_pkg::STAT_PRESENT;
        end else begin
            stat_eval = lcabl_pkg::STAT_OK;
        end
    end

    assign ins_ok    = (cmd_reg == lcabl_pkg::CMD_INSERT) && (stat_eval == lcabl_pkg::STAT_OK);
    assign lvl_start = (cmd_reg == lcabl_pkg::CMD_QUERY) ? LW'(LEVELS - 1) : LW'(1);
    assign lvl_last  = (cmd_reg == lcabl_pkg::CMD_QUERY) ? (lvl_reg == '0)
                                                          : (lvl_reg == LW'(LEVELS - 1));

    assign stat.clr_last = &clr_reg;
    assign stat.is_query = (cmd_reg == lcabl_pkg::CMD_QUERY);
    assign stat.err      = (stat_eval != lcabl_pkg::STAT_OK);
    assign stat.lvl_last = lvl_last;
    assign stat.same     = (x_reg == y_reg);
    assign stat.out_free = !out_valid_reg || m_tready;

    // memory addresses and writes
    always_comb begin
        pres_we = 1'b0;
        pres_wa = a_idx;
        pres_wd = 1'b0;
        dep_we  = 1'b0;
        dep_wa  = a_idx;
        dep_wd  = dep_inc;
        anc_we  = 1'b0;
        anc_wa  = {a_idx, lvl_reg};
        anc_wd  = anc_v0;
        dep_ra0 = a_idx;
        anc_ra0 = {x_idx, lvl_reg};
        anc_ra1 = {y_idx, lvl_reg};
        case (cmd.op)
            lcabl_pkg::OP_CLEAR: begin
                pres_we = 1'b1;
                pres_wa = clr_reg;
            end
            lcabl_pkg::OP_EVAL: begin
                dep_we = ins_ok;
                anc_we = ins_ok;
                anc_wa = {a_idx, LW'(0)};
                anc_wd = b_reg;
            end
            lcabl_pkg::OP_INS_RD: begin
                anc_ra0 = {x_idx, LW'(lvl_reg - LW'(1))};
            end
            lcabl_pkg::OP_INS_WR: begin
                anc_we = 1'b1;
                if (lvl_last) begin
                    pres_we = 1'b1;
                    pres_wd = 1'b1;
                end
            end
            lcabl_pkg::OP_LIFT_DEP: begin
                dep_ra0 = p_idx;
            end
            lcabl_pkg::OP_ROOT_RD: begin
                anc_ra0 = {x_idx, LW'(0)};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (pres_we) pres_mem[pres_wa] <= pres_wd;
        if (dep_we)  dep_mem[dep_wa]   <= dep_wd;
        if (anc_we)  anc_mem[anc_wa]   <= anc_wd;
        pres_rd0_reg <= pres_mem[a_idx];
        pres_rd1_reg <= pres_mem[b_idx];
        dep_rd0_reg  <= dep_mem[dep_ra0];
        dep_rd1_reg  <= dep_mem[b_idx];
        anc_rd0_reg  <= anc_mem[anc_ra0];
        anc_rd1_reg  <= anc_mem[anc_ra1];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg       <= '0;
            lvl_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.op == lcabl_pkg::OP_CLEAR) clr_reg <= clr_reg + NODE_BITS'(1);
            if (cmd.lvl_init) begin
                lvl_reg <= lvl_start;
            end else if (cmd.lvl_step) begin
                lvl_reg <= (cmd_reg == lcabl_pkg::CMD_QUERY) ? lvl_reg - LW'(1)
                                                             : lvl_reg + LW'(1);
            end
            if (cmd.op == lcabl_pkg::OP_FINISH) out_valid_reg <= 1'b1;
            else if (m_tready)                  out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        dep_z0_reg <= (cmd.op == lcabl_pkg::OP_LIFT_DEP) ? (p_val == '0) : (a_reg == '0);
        dep_z1_reg <= (b_reg == '0);
        anc_z0_reg <= (x_reg == '0);
        anc_z1_reg <= (y_reg == '0);
        case (cmd.op)
            lcabl_pkg::OP_LOAD: begin
                cmd_reg <= in_cmd;
                a_reg   <= in_node_a;
                b_reg   <= in_node_b;
            end
            lcabl_pkg::OP_EVAL: begin
                stat_reg <= stat_eval;
                res_reg  <= '0;
                if (cmd_reg == lcabl_pkg::CMD_INSERT) begin
                    x_reg <= b_reg;
                end else if (dep_v0 < dep_v1) begin
                    x_reg  <= b_reg;
                    y_reg  <= a_reg;
                    dy_reg <= dep_v0;
                end else begin
                    x_reg  <= a_reg;
                    y_reg  <= b_reg;
                    dy_reg <= dep_v1;
                end
            end
            lcabl_pkg::OP_INS_WR: begin
                x_reg <= anc_v0;
            end
            lcabl_pkg::OP_LIFT_DEP: begin
                p_reg <= p_val;
            end
            lcabl_pkg::OP_LIFT_UPD: begin
                if (dep_v0 >= dy_reg) x_reg <= p_reg;
            end
            lcabl_pkg::OP_SAME: begin
                if (x_reg == y_reg) res_reg <= x_reg;
            end
            lcabl_pkg::OP_CLIMB_UPD: begin
                if (anc_v0 != anc_v1) begin
                    x_reg <= anc_v0;
                    y_reg <= anc_v1;
                end
            end
            lcabl_pkg::OP_ROOT_UPD: begin
                res_reg <= anc_v0;
            end
            lcabl_pkg::OP_FINISH: begin
                out_stat_reg <= stat_reg;
                out_anc_reg  <= res_reg;
                if (cmd_reg != lcabl_pkg::CMD_QUERY || stat_reg != lcabl_pkg::STAT_OK) begin
                    out_rel_reg <= lcabl_pkg::REL_NONE;
                end else if (res_reg == a_reg) begin
                    out_rel_reg <= lcabl_pkg::REL_A_ANC;
                end else if (res_reg == b_reg) begin
                    out_rel_reg <= lcabl_pkg::REL_B_ANC;
                end else begin
                    out_rel_reg <= lcabl_pkg::REL_NONE;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_stat_reg, out_anc_reg, out_rel_reg};

endmodule

// ===== hdl/lcabl_checker.sv =====
module lcabl_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [lcabl_pkg::IN_DATA_W-1:0]     s_tdata,
    input logic                                s_tuser,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [lcabl_pkg::OUT_DATA_W-1:0]    m_tdata
);

    // a request is worked on alone: no accept in the cycle after one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted back to back");

    // a failed request carries no relation and no ancestor
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[19:18] != lcabl_pkg::STAT_OK) |-> (m_tdata[17:0] == 18'd0))
        else $error("error result with nonzero payload");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] != 2'd3 && m_tdata[19:18] != 2'd3 &&
                      m_tdata[23:20] == 4'd0))
        else $error("illegal result code");

    // relation set means the ancestor is one of the named nodes, so never node 0
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1:0] != lcabl_pkg::REL_NONE) |-> (m_tdata[17:2] != 16'd0))
        else $error("relation reported with ancestor 0");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind lca_binary_lifting_top lcabl_checker u_lcabl_checker (.*);

// ===== sim/lca_result_checker.sv =====
`timescale 1ns / 1ps

module lca_result_checker
    import lcabl_pkg::*;
#(
    parameter int LEVELS = LEVELS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // node_a[15:0], node_b[31:16]
    input  logic                  s_tuser,   // cmd[0]
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,   // relation[1:0], ancestor[17:2],
                                             // status[19:18], zero[23:20]
    output int                    mismatches,
    output int                    outstanding,
    output int                    checked
);

    typedef struct packed {
        rel_t            relation;
        logic [ID_W-1:0] ancestor;
        stat_t           status;
    } lca_answer_t;

    // forest copy: presence, depth and the 2^k jump table, keyed by node id
    bit                 node_seen [int];
    logic [DEPTH_W-1:0] depth_tab [int];
    logic [ID_W-1:0]    jump_tab  [int];
    lca_answer_t        answers_due [$];

    int fail_cnt  = 0;
    int match_cnt = 0;

    function automatic bit is_known(logic [ID_W-1:0] n);
        return n != '0 && node_seen.exists(int'(n));
    endfunction

    // node 0 sits above every root: depth 0, every jump lands on 0
    function automatic logic [DEPTH_W-1:0] depth_of(logic [ID_W-1:0] n);
        if (n == '0 || !depth_tab.exists(int'(n)))
            return '0;
        return depth_tab[int'(n)];
    endfunction

    function automatic logic [ID_W-1:0] jump(logic [ID_W-1:0] n, int k);
        int key;
        key = int'(n) * LEVELS + k;
        if (n == '0 || !jump_tab.exists(key))
            return '0;
        return jump_tab[key];
    endfunction

    function automatic logic [ID_W-1:0] common_ancestor(logic [ID_W-1:0] x,
                                                       logic [ID_W-1:0] y);
        logic [ID_W-1:0] t;
        logic [ID_W-1:0] px;
        logic [ID_W-1:0] py;
        int              k;
        if (depth_of(x) < depth_of(y)) begin
            t = x;
            x = y;
            y = t;
        end
        // raise the deeper node to the depth of the other
        for (k = LEVELS - 1; k >= 0; k--)
            if (depth_of(jump(x, k)) >= depth_of(y))
                x = jump(x, k);
        if (x == y)
            return x;
        // climb both while their ancestors still differ
        for (k = LEVELS - 1; k >= 0; k--) begin
            px = jump(x, k);
            py = jump(y, k);
            if (px != py) begin
                x = px;
                y = py;
            end
        end
        return jump(x, 0);
    endfunction

    function automatic lca_answer_t predict_request(logic cmd, logic [ID_W-1:0] a,
                                                    logic [ID_W-1:0] b);
        lca_answer_t    ans;
        logic [DEPTH_W:0] d;
        int             k;
        ans.relation = REL_NONE;
        ans.ancestor = '0;
        ans.status   = STAT_OK;
        if (cmd == CMD_INSERT) begin
            if (a == '0 || !(b == '0 || is_known(b))) begin
                ans.status = STAT_UNKNOWN;
            end else if (node_seen.exists(int'(a))) begin
                ans.status = STAT_PRESENT;
            end else begin
                d = {1'b0, depth_of(b)} + 1'b1;
                depth_tab[int'(a)] = d[DEPTH_W] ? {DEPTH_W{1'b1}} : d[DEPTH_W-1:0];
                jump_tab[int'(a) * LEVELS] = b;
                for (k = 1; k < LEVELS; k++)
                    jump_tab[int'(a) * LEVELS + k] = jump(jump(a, k - 1), k - 1);
                node_seen[int'(a)] = 1'b1;
            end
        end else begin
            if (!is_known(a) || !is_known(b)) begin
                ans.status = STAT_UNKNOWN;
            end else begin
                ans.ancestor = common_ancestor(a, b);
                if (ans.ancestor == a)
                    ans.relation = REL_A_ANC;
                else if (ans.ancestor == b)
                    ans.relation = REL_B_ANC;
            end
        end
        return ans;
    endfunction

    always @(posedge aclk) begin
        lca_answer_t want;
        if (!aresetn) begin
            node_seen.delete();
            depth_tab.delete();
            jump_tab.delete();
            answers_due.delete();
        end else begin
            if (s_tvalid && s_tready)
                answers_due.push_back(predict_request(s_tuser, s_tdata[15:0],
                                                      s_tdata[31:16]));
            if (m_tvalid && m_tready) begin
                if (answers_due.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("%0t: result with no request pending: data %h",
                                 $realtime, m_tdata);
                end else begin
                    want = answers_due.pop_front();
                    if (m_tdata[1:0] != want.relation || m_tdata[17:2] != want.ancestor ||
                        m_tdata[19:18] != want.status || m_tdata[23:20] != 4'd0) begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                            $display({"%0t: mismatch relation exp %0d got %0d, ancestor ",
                                      "exp %0d got %0d, status exp %0d got %0d, pad %h"},
                                     $realtime, want.relation, m_tdata[1:0],
                                     want.ancestor, m_tdata[17:2], want.status,
                                     m_tdata[19:18], m_tdata[23:20]);
                    end else begin
                        match_cnt++;
                    end
                end
            end
        end
        mismatches  <= fail_cnt;
        checked     <= match_cnt;
        outstanding <= answers_due.size();
    end

endmodule

// ===== sim/tb_lca_binary_lifting_top.sv =====
`timescale 1ns / 1ps

module tb_lca_binary_lifting_top;
    import lcabl_pkg::*;

    localparam int TOTAL_REQUESTS  = 850;
    localparam int DIRECTED_COUNT  = 24;
    localparam int RANDOM_REQUESTS = TOTAL_REQUESTS - DIRECTED_COUNT;
    // covers the post-reset clear sweep several times over
    localparam int STALL_LIMIT     = 300000;
    localparam int DRAIN_CYCLES    = 100;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;   // node_a[15:0], node_b[31:16]
    logic                  s_tuser  = 1'b0; // cmd[0]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // relation[1:0], ancestor[17:2],
                                            // status[19:18], zero[23:20]

    int mismatches;
    int outstanding;
    int checked;

    bit quiet_stretch = 1'b0;
    int ready_hold    = 0;
    int idle_cycles   = 0;

    // what the stimulus has built so far, used to aim requests and in the closing report
    bit              taken     [int];
    logic [ID_W-1:0] parent_of [int];
    int              level_of  [int];
    logic [ID_W-1:0] members   [$];
    logic [ID_W-1:0] last_node = '0;
    int              sent_inserts = 0;
    int              sent_queries = 0;
    int              deepest      = 0;

    initial forever #10 aclk = ~aclk;

    lca_binary_lifting_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    lca_result_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked)
    );

    // result side: hold each shown result back by a random draw before taking it; quiet stretches take it at once
    always @(posedge aclk) begin
        int draw;
        draw = $urandom_range(0, 4);
        if (!aresetn) begin
            m_tready   <= 1'b0;
            ready_hold <= 0;
        end else if (m_tvalid && m_tready) begin
            ready_hold <= quiet_stretch ? 0 : draw;
            m_tready   <= quiet_stretch || (draw == 0);
        end else if (m_tvalid && !m_tready) begin
            if (ready_hold > 1) begin
                ready_hold <= ready_hold - 1;
            end else begin
                ready_hold <= 0;
                m_tready   <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("FAIL lca_binary_lifting_top");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic void note_insert(logic [ID_W-1:0] a, logic [ID_W-1:0] b);
        if (a != '0 && !taken.exists(int'(a)) && (b == '0 || taken.exists(int'(b)))) begin
            taken[int'(a)]     = 1'b1;
            parent_of[int'(a)] = b;
            level_of[int'(a)]  = (b == '0) ? 1 : level_of[int'(b)] + 1;
            members.push_back(a);
            last_node = a;
            if (level_of[int'(a)] > deepest)
                deepest = level_of[int'(a)];
        end
    endfunction

    function automatic logic [ID_W-1:0] fresh_node();
        logic [ID_W-1:0] n;
        do
            n = ID_W'($urandom_range(1, 65535));
        while (taken.exists(int'(n)));
        return n;
    endfunction

    function automatic logic [ID_W-1:0] any_member();
        return members[$urandom_range(0, members.size() - 1)];
    endfunction

    function automatic logic [ID_W-1:0] climb(logic [ID_W-1:0] n, int steps);
        while (steps > 0 && parent_of[int'(n)] != '0) begin
            n = parent_of[int'(n)];
            steps--;
        end
        return n;
    endfunction

    task automatic send_request(input logic cmd, input logic [ID_W-1:0] a,
                                input logic [ID_W-1:0] b);
        int gap;
        gap = quiet_stretch ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {b, a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (cmd == CMD_INSERT) begin
            note_insert(a, b);
            sent_inserts++;
        end else begin
            sent_queries++;
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    initial begin
        int              pick;
        int              sel;
        int              chain_bias;
        int              insert_share;
        logic [ID_W-1:0] a;
        logic [ID_W-1:0] b;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty forest, bad ids, roots at both extremes, duplicates
        send_request(CMD_QUERY,  16'd5,      16'd6);
        send_request(CMD_INSERT, 16'd0,      16'd0);
        send_request(CMD_INSERT, 16'd7,      16'd9);
        send_request(CMD_INSERT, 16'd1,      16'd0);
        send_request(CMD_INSERT, 16'hFFFF,   16'd0);
        send_request(CMD_INSERT, 16'd2,      16'd1);
        send_request(CMD_INSERT, 16'd3,      16'd1);
        send_request(CMD_INSERT, 16'd4,      16'd2);
        send_request(CMD_INSERT, 16'h8000,   16'd4);
        send_request(CMD_INSERT, 16'd2,      16'd1);
        // duplicate node under an unknown parent: unknown wins
        send_request(CMD_INSERT, 16'd3,      16'h1234);
        send_request(CMD_INSERT, 16'h7FFF,   16'h8000);
        send_request(CMD_QUERY,  16'd4,      16'd3);
        send_request(CMD_QUERY,  16'd1,      16'h7FFF);
        send_request(CMD_QUERY,  16'h7FFF,   16'd2);
        send_request(CMD_QUERY,  16'd4,      16'd4);
        send_request(CMD_QUERY,  16'h8000,   16'hFFFF);
        send_request(CMD_QUERY,  16'd0,      16'd1);
        send_request(CMD_QUERY,  16'd1,      16'd0);
        send_request(CMD_QUERY,  16'd3,      16'h4321);
        send_request(CMD_QUERY,  16'hFFFF,   16'hFFFF);
        send_request(CMD_INSERT, 16'h5555,   16'hFFFF);
        send_request(CMD_QUERY,  16'h5555,   16'h7FFF);
        send_request(CMD_INSERT, 16'hFFFF,   16'd0);

        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            quiet_stretch = (i % 200) >= 150;
            if (i == RANDOM_REQUESTS / 2)
                wait_drained();
            // early on grow one long chain so the lifting spans many levels
            chain_bias   = (i < 150) ? 85 : 40;
            insert_share = (i < 150) ? 70 : 40;
            pick = $urandom_range(0, 99);
            if (pick < insert_share || members.size() < 2) begin
                a   = fresh_node();
                sel = $urandom_range(0, 99);
                if (sel < 5)
                    b = '0;
                else if (sel < chain_bias)
                    b = last_node;
                else
                    b = any_member();
                send_request(CMD_INSERT, a, b);
            end else if (pick < 75) begin
                send_request(CMD_QUERY, any_member(), any_member());
            end else if (pick < 88) begin
                a = any_member();
                b = climb(a, $urandom_range(0, 40));
                if ($urandom_range(0, 1))
                    send_request(CMD_QUERY, a, b);
                else
                    send_request(CMD_QUERY, b, a);
            end else begin
                // malformed requests and raw noise
                case (pick % 5)
                    0: send_request(CMD_INSERT, any_member(), any_member());
                    1: send_request(CMD_INSERT, fresh_node(), fresh_node());
                    2: send_request(1'($urandom_range(0, 1)), '0, any_member());
                    3: send_request(CMD_QUERY, any_member(), fresh_node());
                    default: send_request(1'($urandom_range(0, 1)), ID_W'($urandom),
                                          ID_W'($urandom));
                endcase
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d inserts and %0d queries over %0d tree nodes, deepest level %0d",
                 sent_inserts, sent_queries, members.size(), deepest);
        $display("%0d results matched, %0d mismatched, %0d still owed",
                 checked, mismatches, outstanding);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS lca_binary_lifting_top");
        else
            $display("FAIL lca_binary_lifting_top");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/lcabl_pkg.sv
hdl/lcabl_ctrl.sv
hdl/lcabl_dpath.sv
hdl/lca_binary_lifting_top.sv
hdl/lcabl_checker.sv
sim/lca_result_checker.sv
sim/tb_lca_binary_lifting_top.sv
